[src/rts_pkg.sv]
package rts_pkg;

    // payload of one input item and one result item
    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } in_item_t;

    typedef struct packed {
        logic signed [48:0] unix_ms;
        logic               status;
    } out_item_t;

    // parser phases
    typedef enum logic [2:0] {
        PH_PREFIX     = 3'd0,
        PH_AFTER_SEC  = 3'd1,
        PH_FRAC_FIRST = 3'd2,
        PH_FRAC       = 3'd3,
        PH_OFFSET     = 3'd4,
        PH_END        = 3'd5
    } parse_phase_t;

    // sequencer states of the date arithmetic
    typedef enum logic [3:0] {
        SQ_PARSE,
        SQ_DIV,
        SQ_D365,
        SQ_DSMALL,
        SQ_DWAIT,
        SQ_DMUL,
        SQ_HOUR,
        SQ_MIN,
        SQ_SEC,
        SQ_ZH,
        SQ_ZM,
        SQ_FRAC,
        SQ_FIN,
        SQ_OUT
    } seq_state_t;

    // accumulator operations of the shared multiply-accumulate unit
    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_CLEAR,
        ACC_ADD
    } acc_op_t;

    localparam int MAC_A_W = 24;
    localparam int MAC_B_W = 28;
    localparam int ACC_W   = 50;

    typedef struct packed {
        acc_op_t                   acc_op;
        logic signed [MAC_A_W-1:0] op_a;
        logic signed [MAC_B_W-1:0] op_b;
    } mac_req_t;

    // parsed fields handed from the parser to the sequencer
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [9:0]  milli;
        logic [1:0]  frac_count;
        logic        zone_sign;
        logic [6:0]  zone_hours;
        logic [6:0]  zone_minutes;
        logic        ok;
    } parse_fields_t;

    // character codes
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_T_UP   = 8'h54;
    localparam logic [7:0] CH_T_LOW  = 8'h74;
    localparam logic [7:0] CH_Z_UP   = 8'h5A;
    localparam logic [7:0] CH_Z_LOW  = 8'h7A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // date arithmetic constants
    localparam logic [14:0] YEAR_SHIFT = 15'd400;     // keeps the shifted year positive
    localparam logic [23:0] DAY_BIAS   = 24'd865565;  // 719468 plus one era of 146097 days
    localparam logic signed [MAC_B_W-1:0] RECIP_100 = 28'sd10486;  // ceil(2^20 / 100)
    localparam int RECIP_SHIFT = 20;
    localparam logic signed [MAC_B_W-1:0] DAYS_PER_YEAR = 28'sd365;
    localparam logic signed [MAC_B_W-1:0] MS_PER_DAY    = 28'sd86400000;
    localparam logic signed [MAC_B_W-1:0] MS_PER_HOUR   = 28'sd3600000;
    localparam logic signed [MAC_B_W-1:0] MS_PER_MIN    = 28'sd60000;
    localparam logic signed [MAC_B_W-1:0] MS_PER_SEC    = 28'sd1000;
    localparam logic signed [MAC_B_W-1:0] MAC_ONE       = 28'sd1;

    // days before the first of a month in a march-based year
    function automatic logic [8:0] doy_base(input logic [3:0] mp);
        logic [8:0] r;
        case (mp)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // pads a short fraction to milliseconds
    function automatic logic signed [MAC_B_W-1:0] frac_scale(input logic [1:0] cnt);
        logic signed [MAC_B_W-1:0] r;
        case (cnt)
            2'd1:    r = 28'sd100;
            2'd2:    r = 28'sd10;
            default: r = 28'sd1;
        endcase
        return r;
    endfunction

endpackage

[src/rfc3339_timestamp_to_unix_ms_top.sv]
// RFC 3339 timestamp to signed Unix milliseconds.
// Input channel s_*: one text character per item with a last-character flag.
// Result channel m_*: one item per string, given after its last character:
// unix_ms and status (status 1 and unix_ms 0 for a malformed string).
// Characters other than the last are accepted back to back.
// After the last character is accepted the block drops s_ready while a
// sequencer runs the days-from-civil rule and the millisecond sum through
// one shared multiply-accumulate unit, one product per cycle. The result
// is loaded from state SQ_OUT, which a malformed string reaches straight
// from SQ_DIV; m_valid rises and s_ready returns in the same cycle.
// The result sits in an output register; while it waits, the parser takes
// the characters of the next string; a further last character is taken, but
// intake then stays off until the held result is taken and the new one loaded.
// Reset (aresetn low, synchronous) clears the parser, the sequencer and
// m_valid. A stalled receiver holds m_data steady until m_ready.
module rfc3339_timestamp_to_unix_ms_top
    import rts_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    seq_state_t    state_reg, state_next;
    logic          err_reg, err_next;
    logic [6:0]    q_reg, q_next;
    logic          m_valid_reg, m_valid_next;
    out_item_t     m_data_reg, m_data_next;

    parse_fields_t fields;
    mac_req_t      mac_req;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] prod;

    logic          s_accept;
    logic          load_out;
    logic          parse_clear;
    logic [14:0]   y_shift;
    logic [3:0]    mp;
    logic [8:0]    doy;
    logic [23:0]   small_sum;

    assign s_accept = s_valid && s_ready;

    rts_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item    (s_data),
        .accept  (s_accept),
        .clear   (parse_clear),
        .fields  (fields)
    );

    rts_mac u_mac (
        .aclk (aclk),
        .req  (mac_req),
        .acc  (acc),
        .prod (prod)
    );

    // shifted year, march-based month and day of year
    always_comb begin
        y_shift   = {1'b0, fields.year} + YEAR_SHIFT
                  - ((fields.month <= 4'd2) ? 15'd1 : 15'd0);
        mp        = (fields.month > 4'd2) ? (fields.month - 4'd3) : (fields.month + 4'd9);
        doy       = doy_base(mp) + {4'b0, fields.day} - 9'd1;
        small_sum = {11'b0, y_shift[14:2]} - {17'b0, q_reg} + {19'b0, q_reg[6:2]}
                  + {15'b0, doy} - DAY_BIAS;
    end

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            SQ_PARSE:  if (s_accept && s_data.last_char) state_next = SQ_DIV;
            SQ_DIV:    state_next = fields.ok ? SQ_D365 : SQ_OUT;
            SQ_D365:   state_next = SQ_DSMALL;
            SQ_DSMALL: state_next = SQ_DWAIT;
            SQ_DWAIT:  state_next = SQ_DMUL;
            SQ_DMUL:   state_next = SQ_HOUR;
            SQ_HOUR:   state_next = SQ_MIN;
            SQ_MIN:    state_next = SQ_SEC;
            SQ_SEC:    state_next = SQ_ZH;
            SQ_ZH:     state_next = SQ_ZM;
            SQ_ZM:     state_next = SQ_FRAC;
            SQ_FRAC:   state_next = SQ_FIN;
            SQ_FIN:    state_next = SQ_OUT;
            SQ_OUT:    if (!m_valid_reg || m_ready) state_next = SQ_PARSE;
            default:   state_next = SQ_PARSE;
        endcase
    end

    // sequencer outputs: handshake and operands of the shared unit
    always_comb begin
        s_ready        = 1'b0;
        load_out       = 1'b0;
        mac_req.acc_op = ACC_HOLD;
        mac_req.op_a   = '0;
        mac_req.op_b   = '0;
        case (state_reg)
            SQ_PARSE: begin
                s_ready = 1'b1;
            end
            SQ_DIV: begin
                // shifted year over 100 by reciprocal
                mac_req.acc_op = ACC_CLEAR;
                mac_req.op_a   = {9'b0, y_shift};
                mac_req.op_b   = RECIP_100;
            end
            SQ_D365: begin
                mac_req.acc_op = ACC_CLEAR;
                mac_req.op_a   = {9'b0, y_shift};
                mac_req.op_b   = DAYS_PER_YEAR;
            end
            SQ_DSMALL: begin
                // leap-day corrections, day of year and epoch bias
                mac_req.acc_op = ACC_ADD;
                mac_req.op_a   = small_sum;
                mac_req.op_b   = MAC_ONE;
            end
            SQ_DWAIT: begin
                mac_req.acc_op = ACC_ADD;
            end
            SQ_DMUL: begin
                mac_req.acc_op = ACC_CLEAR;
                mac_req.op_a   = {acc[22], acc[22:0]};
                mac_req.op_b   = MS_PER_DAY;
            end
            SQ_HOUR: begin
                mac_req.acc_op = ACC_ADD;
                mac_req.op_a   = {19'b0, fields.hour};
                mac_req.op_b   = MS_PER_HOUR;
            end
            SQ_MIN: begin
                mac_req.acc_op = ACC_ADD;
                mac_req.op_a   = {18'b0, fields.minute};
                mac_req.op_b   = MS_PER_MIN;
            end
            SQ_SEC: begin
                mac_req.acc_op = ACC_ADD;
                mac_req.op_a   = {18'b0, fields.second};
                mac_req.op_b   = MS_PER_SEC;
            end
            SQ_ZH: begin
                // a plus zone is subtracted, a minus zone added
                mac_req.acc_op = ACC_ADD;
                mac_req.op_a   = {17'b0, fields.zone_hours};
                mac_req.op_b   = fields.zone_sign ? MS_PER_HOUR : -MS_PER_HOUR;
            end
            SQ_ZM: begin
                mac_req.acc_op = ACC_ADD;
                mac_req.op_a   = {17'b0, fields.zone_minutes};
                mac_req.op_b   = fields.zone_sign ? MS_PER_MIN : -MS_PER_MIN;
            end
            SQ_FRAC: begin
                mac_req.acc_op = ACC_ADD;
                mac_req.op_a   = {14'b0, fields.milli};
                mac_req.op_b   = frac_scale(fields.frac_count);
            end
            SQ_FIN: begin
                mac_req.acc_op = ACC_ADD;
            end
            SQ_OUT: begin
                load_out = !m_valid_reg || m_ready;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    assign parse_clear = load_out;

    // status, quotient and output register
    always_comb begin
        err_next     = (state_reg == SQ_DIV) ? !fields.ok : err_reg;
        q_next       = (state_reg == SQ_D365) ? prod[RECIP_SHIFT+6:RECIP_SHIFT] : q_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (load_out) begin
            m_valid_next       = 1'b1;
            m_data_next.status = err_reg;
            m_data_next.unix_ms = err_reg ? '0 : acc[48:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= SQ_PARSE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        err_reg    <= err_next;
        q_reg      <= q_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTH
    // the last character stops intake until the result is built
    a_last_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.last_char) |=> !s_ready)
        else $error("intake not stopped after last character");

    // a malformed string always reports zero milliseconds
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status) |-> (m_data.unix_ms == '0))
        else $error("malformed result with nonzero milliseconds");

    // a new result only comes out of the final sequencer state
    a_out_from_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == SQ_OUT))
        else $error("result raised outside the output state");

    // intake resumes exactly when the result register is loaded
    a_ready_with_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SQ_OUT && (!m_valid || m_ready)) |=> (s_ready && m_valid))
        else $error("intake and result load out of step");
`endif

endmodule

[src/rts_parser.sv]
module rts_parser
    import rts_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  in_item_t      item,
    input  logic          accept,
    input  logic          clear,
    output parse_fields_t fields
);

    // character positions inside the date and time prefix
    localparam logic [4:0] IDX_DASH1  = 5'd4;
    localparam logic [4:0] IDX_DASH2  = 5'd7;
    localparam logic [4:0] IDX_T      = 5'd10;
    localparam logic [4:0] IDX_COLON1 = 5'd13;
    localparam logic [4:0] IDX_COLON2 = 5'd16;
    localparam logic [4:0] IDX_YEAR_L = 5'd3;
    localparam logic [4:0] IDX_MON_L  = 5'd6;
    localparam logic [4:0] IDX_DAY_L  = 5'd9;
    localparam logic [4:0] IDX_HOUR_L = 5'd12;
    localparam logic [4:0] IDX_MIN_L  = 5'd15;
    localparam logic [4:0] IDX_SEC_L  = 5'd18;
    // positions inside a numeric zone offset
    localparam logic [4:0] IDX_OFF_COLON = 5'd2;
    localparam logic [4:0] IDX_OFF_LAST  = 5'd4;

    parse_phase_t phase_reg, phase_next;
    logic [4:0]  idx_reg, idx_next;
    logic [13:0] year_reg, year_next;
    logic [3:0]  month_reg, month_next;
    logic [4:0]  day_reg, day_next;
    logic [4:0]  hour_reg, hour_next;
    logic [5:0]  minute_reg, minute_next;
    logic [5:0]  second_reg, second_next;
    logic [9:0]  milli_reg, milli_next;
    logic [1:0]  fcount_reg, fcount_next;
    logic        zsign_reg, zsign_next;
    logic [6:0]  zhours_reg, zhours_next;
    logic [6:0]  zmins_reg, zmins_next;
    logic        error_reg, error_next;

    logic [7:0]  c;
    logic [3:0]  dval;
    logic        dig;
    logic        zone_letter;
    logic        zone_signch;
    logic [17:0] year_acc, month_acc, day_acc, hour_acc, minute_acc, second_acc;
    logic [17:0] milli_acc, zhours_acc, zmins_acc;

    // shift-add times ten plus a digit
    function automatic logic [17:0] mul10_add(input logic [13:0] acc, input logic [3:0] d);
        logic [17:0] a;
        a = {4'b0, acc};
        return (a << 3) + (a << 1) + {14'b0, d};
    endfunction

    // character classes
    always_comb begin
        c           = item.char_code;
        dval        = item.char_code[3:0];
        dig         = (c >= CH_ZERO) && (c <= CH_NINE);
        zone_letter = (c == CH_Z_UP) || (c == CH_Z_LOW);
        zone_signch = (c == CH_PLUS) || (c == CH_DASH);
    end

    // field accumulators
    always_comb begin
        year_acc   = mul10_add(year_reg, dval);
        month_acc  = mul10_add({10'b0, month_reg}, dval);
        day_acc    = mul10_add({9'b0, day_reg}, dval);
        hour_acc   = mul10_add({9'b0, hour_reg}, dval);
        minute_acc = mul10_add({8'b0, minute_reg}, dval);
        second_acc = mul10_add({8'b0, second_reg}, dval);
        milli_acc  = mul10_add({4'b0, milli_reg}, dval);
        zhours_acc = mul10_add({7'b0, zhours_reg}, dval);
        zmins_acc  = mul10_add({7'b0, zmins_reg}, dval);
    end

    // next parser state
    always_comb begin
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        milli_next  = milli_reg;
        fcount_next = fcount_reg;
        zsign_next  = zsign_reg;
        zhours_next = zhours_reg;
        zmins_next  = zmins_reg;
        error_next  = error_reg;
        if (clear) begin
            phase_next  = PH_PREFIX;
            idx_next    = '0;
            year_next   = '0;
            month_next  = '0;
            day_next    = '0;
            hour_next   = '0;
            minute_next = '0;
            second_next = '0;
            milli_next  = '0;
            fcount_next = '0;
            zsign_next  = 1'b0;
            zhours_next = '0;
            zmins_next  = '0;
            error_next  = 1'b0;
        end else if (accept && !error_reg) begin
            case (phase_reg)
                PH_PREFIX: begin
                    if (idx_reg == IDX_DASH1 || idx_reg == IDX_DASH2) begin
                        if (c != CH_DASH) error_next = 1'b1;
                    end else if (idx_reg == IDX_T) begin
                        if (c != CH_T_UP && c != CH_T_LOW) error_next = 1'b1;
                    end else if (idx_reg == IDX_COLON1 || idx_reg == IDX_COLON2) begin
                        if (c != CH_COLON) error_next = 1'b1;
                    end else if (!dig) begin
                        error_next = 1'b1;
                    end else if (idx_reg <= IDX_YEAR_L) begin
                        year_next = year_acc[13:0];
                    end else if (idx_reg <= IDX_MON_L) begin
                        month_next = month_acc[3:0];
                        if (idx_reg == IDX_MON_L && (month_acc < 18'd1 || month_acc > 18'd12))
                            error_next = 1'b1;
                    end else if (idx_reg <= IDX_DAY_L) begin
                        day_next = day_acc[4:0];
                        if (idx_reg == IDX_DAY_L && (day_acc < 18'd1 || day_acc > 18'd31))
                            error_next = 1'b1;
                    end else if (idx_reg <= IDX_HOUR_L) begin
                        hour_next = hour_acc[4:0];
                        if (idx_reg == IDX_HOUR_L && hour_acc > 18'd23) error_next = 1'b1;
                    end else if (idx_reg <= IDX_MIN_L) begin
                        minute_next = minute_acc[5:0];
                        if (idx_reg == IDX_MIN_L && minute_acc > 18'd59) error_next = 1'b1;
                    end else begin
                        second_next = second_acc[5:0];
                        if (idx_reg == IDX_SEC_L && second_acc > 18'd60) error_next = 1'b1;
                    end
                    if (idx_reg >= IDX_SEC_L) begin
                        phase_next = PH_AFTER_SEC;
                        idx_next   = '0;
                    end else begin
                        idx_next = idx_reg + 5'd1;
                    end
                end
                PH_AFTER_SEC: begin
                    if (c == CH_DOT) begin
                        phase_next = PH_FRAC_FIRST;
                    end else if (zone_letter) begin
                        phase_next = PH_END;
                    end else if (zone_signch) begin
                        zsign_next = (c == CH_DASH);
                        phase_next = PH_OFFSET;
                        idx_next   = '0;
                    end else begin
                        error_next = 1'b1;
                    end
                end
                PH_FRAC_FIRST, PH_FRAC: begin
                    if (dig) begin
                        if (fcount_reg != 2'd3) begin
                            milli_next  = milli_acc[9:0];
                            fcount_next = fcount_reg + 2'd1;
                        end
                        phase_next = PH_FRAC;
                    end else if (phase_reg == PH_FRAC_FIRST) begin
                        error_next = 1'b1;
                    end else if (zone_letter) begin
                        phase_next = PH_END;
                    end else if (zone_signch) begin
                        zsign_next = (c == CH_DASH);
                        phase_next = PH_OFFSET;
                        idx_next   = '0;
                    end else begin
                        error_next = 1'b1;
                    end
                end
                PH_OFFSET: begin
                    if (idx_reg == IDX_OFF_COLON) begin
                        if (c != CH_COLON) error_next = 1'b1;
                    end else if (!dig) begin
                        error_next = 1'b1;
                    end else if (idx_reg < IDX_OFF_COLON) begin
                        zhours_next = zhours_acc[6:0];
                    end else begin
                        zmins_next = zmins_acc[6:0];
                    end
                    if (idx_reg >= IDX_OFF_LAST) begin
                        phase_next = PH_END;
                        idx_next   = '0;
                    end else begin
                        idx_next = idx_reg + 5'd1;
                    end
                end
                default: begin
                    // anything after a complete zone
                    error_next = 1'b1;
                end
            endcase
        end
    end

    // parser registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_PREFIX;
            idx_reg    <= '0;
            year_reg   <= '0;
            month_reg  <= '0;
            day_reg    <= '0;
            hour_reg   <= '0;
            minute_reg <= '0;
            second_reg <= '0;
            milli_reg  <= '0;
            fcount_reg <= '0;
            zsign_reg  <= 1'b0;
            zhours_reg <= '0;
            zmins_reg  <= '0;
            error_reg  <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            year_reg   <= year_next;
            month_reg  <= month_next;
            day_reg    <= day_next;
            hour_reg   <= hour_next;
            minute_reg <= minute_next;
            second_reg <= second_next;
            milli_reg  <= milli_next;
            fcount_reg <= fcount_next;
            zsign_reg  <= zsign_next;
            zhours_reg <= zhours_next;
            zmins_reg  <= zmins_next;
            error_reg  <= error_next;
        end
    end

    // fields to the sequencer
    always_comb begin
        fields.year         = year_reg;
        fields.month        = month_reg;
        fields.day          = day_reg;
        fields.hour         = hour_reg;
        fields.minute       = minute_reg;
        fields.second       = second_reg;
        fields.milli        = milli_reg;
        fields.frac_count   = fcount_reg;
        fields.zone_sign    = zsign_reg;
        fields.zone_hours   = zhours_reg;
        fields.zone_minutes = zmins_reg;
        fields.ok           = !error_reg && (phase_reg == PH_END);
    end

endmodule

[src/rts_mac.sv]
module rts_mac
    import rts_pkg::*;
(
    input  logic                    aclk,
    input  mac_req_t                req,
    output logic signed [ACC_W-1:0] acc,
    output logic signed [ACC_W-1:0] prod
);

    logic signed [MAC_A_W+MAC_B_W-1:0] prod_full;
    logic signed [ACC_W-1:0]           prod_reg, prod_next;
    logic signed [ACC_W-1:0]           acc_reg, acc_next;

    // one signed multiply per cycle, registered before the accumulate
    assign prod_full = req.op_a * req.op_b;
    assign prod_next = prod_full[ACC_W-1:0];

    // clear, hold, or accumulate the registered product of the previous request
    always_comb begin
        case (req.acc_op)
            ACC_CLEAR: acc_next = '0;
            ACC_ADD:   acc_next = acc_reg + prod_reg;
            default:   acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign acc  = acc_reg;
    assign prod = prod_reg;

endmodule
